/* hdl/assert_macros.svh */
// assertion helper macros
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define ASSERT_IMPLIES(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("assertion failed");
`endif

/* hdl/hbmt_pkg.sv */
// ----------------------------------------------------------------------------
// hbmt_pkg
// shared constants and types of the heartbeat membership table
// ----------------------------------------------------------------------------
`default_nettype none
package hbmt_pkg;
  localparam int unsigned TABLE_DEPTH_DEF = 16;

  localparam logic [1:0] REQ_TICK      = 2'd0;
  localparam logic [1:0] REQ_JOIN      = 2'd1;
  localparam logic [1:0] REQ_JOIN_REPLY = 2'd2;
  localparam logic [1:0] REQ_HEARTBEAT = 2'd3;

  localparam logic KIND_HEARTBEAT = 1'b0;
  localparam logic KIND_JOIN_LIST = 1'b1;

  localparam logic [2:0] CFG_SELF_ID     = 3'd0;
  localparam logic [2:0] CFG_SELF_PORT   = 3'd1;
  localparam logic [2:0] CFG_FAIL_PERIOD = 3'd2;
  localparam logic [2:0] CFG_REMOVE_TMO  = 3'd3;
  localparam logic [2:0] CFG_START_GROUP = 3'd4;

  typedef enum logic [7:0] {
    ST_IDLE   = 8'b0000_0001,
    ST_SCAN   = 8'b0000_0010,
    ST_APPLY  = 8'b0000_0100,
    ST_SELF   = 8'b0000_1000,
    ST_LIST   = 8'b0001_0000,
    ST_BEAT   = 8'b0010_0000,
    ST_EXPIRE = 8'b0100_0000,
    ST_FIN    = 8'b1000_0000
  } state_t;
endpackage
`default_nettype wire

/* hdl/heartbeat_membership_table_core.sv */
// ----------------------------------------------------------------------------
// heartbeat_membership_table_core
// gossip heartbeat membership list of one node
// ----------------------------------------------------------------------------
// One item is taken at a time. A sequencer walks the table one entry per cycle,
// pausing while a result waits on out_stall, and in_stall stays high until the
// item is done. The steps of each item:
//   misaddressed item, or a tick while out of group: dropped
//   heartbeat or join-reply entry: scan the table, then apply the entry
//   join request: scan, apply, then send the own entry and the member list
//   tick: heartbeats to all members when the ping countdown is zero, then expiry
// Each result is held in an output register until transferred. The entry
// store is flip-flops with one entry read per cycle at the walk index (at the
// found position while applying). Configuration registers are written only
// when the block is idle, no input is offered and no result is waiting.
`default_nettype none
`include "assert_macros.svh"
module heartbeat_membership_table_core #(
  parameter int unsigned TABLE_DEPTH = hbmt_pkg::TABLE_DEPTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_req_type,
  input  wire logic [30:0] in_dest_id,
  input  wire logic signed [15:0] in_dest_port,
  input  wire logic [30:0] in_member_id,
  input  wire logic signed [15:0] in_member_port,
  input  wire logic signed [31:0] in_member_heartbeat,
  input  wire logic signed [31:0] in_member_timestamp,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             out_out_kind,
  output logic [30:0]      out_to_id,
  output logic signed [15:0] out_to_port,
  output logic [30:0]      out_entry_id,
  output logic signed [15:0] out_entry_port,
  output logic signed [31:0] out_entry_heartbeat,
  output logic signed [31:0] out_entry_timestamp,
  output logic             out_last,
  output logic             out_in_group,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);
  import hbmt_pkg::*;
  localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  logic [30:0] self_id_r;
  logic [15:0] self_port_r, fail_period_r, remove_tmo_r;
  logic        joined_r;
  logic [31:0] own_beat_r, clock_r;
  logic [15:0] ping_r;

  logic [30:0] mem_id   [TABLE_DEPTH];
  logic [15:0] mem_port [TABLE_DEPTH];
  logic [31:0] mem_beat [TABLE_DEPTH];
  logic [31:0] mem_seen [TABLE_DEPTH];
  logic [CW-1:0] count_r;

  state_t      state_r;
  logic [1:0]  typ_r;
  logic [30:0] mid_r;
  logic [15:0] mport_r;
  logic [31:0] mbeat_r, mseen_r;
  logic [CW-1:0] idx_r, wr_r;
  logic        found_r;
  logic [IW-1:0] pos_r;

  logic        ov_r;
  logic        okind_r, olast_r, ogrp_r;
  logic [30:0] oto_id_r, oent_id_r;
  logic [15:0] oto_port_r, oent_port_r;
  logic [31:0] obeat_r, oseen_r;

  logic in_acc, out_free, dest_ok, emit_now;
  logic [IW-1:0] ri;
  logic signed [32:0] age;
  logic at_end;

  assign in_stall  = (state_r != ST_IDLE);
  assign cfg_ready = (state_r == ST_IDLE) && !in_valid && !ov_r;
  assign in_acc    = in_valid && !in_stall;
  assign out_free  = !ov_r || !out_stall;
  assign ri        = idx_r[IW-1:0];
  assign at_end    = (idx_r == count_r);
  assign dest_ok   = (in_dest_id == self_id_r) && (in_dest_port == self_port_r);
  assign age = $signed({clock_r[31], clock_r}) - $signed({mem_seen[ri][31], mem_seen[ri]});
  // a result register is loaded this cycle
  assign emit_now  = out_free && ((state_r == ST_SELF) || (state_r == ST_LIST) ||
                                  (state_r == ST_BEAT && !at_end));

  assign out_valid           = ov_r;
  assign out_out_kind        = okind_r;
  assign out_to_id           = oto_id_r;
  assign out_to_port         = oto_port_r;
  assign out_entry_id        = oent_id_r;
  assign out_entry_port      = oent_port_r;
  assign out_entry_heartbeat = obeat_r;
  assign out_entry_timestamp = oseen_r;
  assign out_last            = olast_r;
  assign out_in_group        = ogrp_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ov_r <= 1'b0;
      ogrp_r <= 1'b0;
      count_r <= '0;
      self_id_r <= '0; self_port_r <= '0; fail_period_r <= 16'd5;
      remove_tmo_r <= 16'd20; joined_r <= 1'b0;
      own_beat_r <= '0; ping_r <= 16'd5; clock_r <= '1;
      idx_r <= '0; wr_r <= '0; found_r <= 1'b0; pos_r <= '0;
    end else begin
      if (ov_r && !out_stall && !emit_now) ov_r <= 1'b0;
      if (emit_now) ogrp_r <= joined_r;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_SELF_ID:     self_id_r <= cfg_data[30:0];
          CFG_SELF_PORT:   self_port_r <= cfg_data[15:0];
          CFG_FAIL_PERIOD: begin fail_period_r <= cfg_data[15:0]; ping_r <= cfg_data[15:0]; end
          CFG_REMOVE_TMO:  remove_tmo_r <= cfg_data[15:0];
          CFG_START_GROUP: joined_r <= cfg_data[0];
          default: ;
        endcase
      end
      case (state_r)
        ST_IDLE: if (in_acc) begin
          typ_r <= in_req_type; mid_r <= in_member_id; mport_r <= in_member_port;
          mbeat_r <= in_member_heartbeat; mseen_r <= in_member_timestamp;
          idx_r <= '0; wr_r <= '0; found_r <= 1'b0; pos_r <= '0;
          if (in_req_type == REQ_TICK) begin
            if (joined_r) state_r <= (ping_r == '0) ? ST_BEAT : ST_EXPIRE;
          end else if (dest_ok) begin
            if (in_req_type == REQ_JOIN_REPLY) joined_r <= 1'b1;
            state_r <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (at_end) state_r <= ST_APPLY;
          else begin
            if (mem_id[ri] == mid_r) begin found_r <= 1'b1; pos_r <= ri; end
            idx_r <= idx_r + 1'b1;
          end
        end
        ST_APPLY: begin
          if (mid_r != self_id_r) begin
            if (found_r) begin
              if (typ_r == REQ_HEARTBEAT &&
                  !($signed(mem_beat[pos_r]) > $signed(mbeat_r))) begin
                mem_beat[pos_r] <= mbeat_r; mem_seen[pos_r] <= clock_r;
              end
            end else if (count_r < CW'(TABLE_DEPTH)) begin
              mem_id[count_r[IW-1:0]]   <= mid_r;
              mem_port[count_r[IW-1:0]] <= mport_r;
              mem_beat[count_r[IW-1:0]] <= mbeat_r;
              mem_seen[count_r[IW-1:0]] <= (typ_r == REQ_JOIN_REPLY) ? mseen_r : clock_r;
              count_r <= count_r + 1'b1;
            end
          end
          idx_r <= '0;
          state_r <= (typ_r == REQ_JOIN) ? ST_SELF : ST_IDLE;
        end
        ST_SELF: if (out_free) begin
          ov_r <= 1'b1; okind_r <= KIND_JOIN_LIST; oto_id_r <= mid_r; oto_port_r <= mport_r;
          oent_id_r <= self_id_r; oent_port_r <= self_port_r;
          obeat_r <= own_beat_r; oseen_r <= clock_r;
          olast_r <= (count_r == '0);
          state_r <= (count_r == '0) ? ST_IDLE : ST_LIST;
        end
        ST_LIST: if (out_free) begin
          ov_r <= 1'b1; okind_r <= KIND_JOIN_LIST; oto_id_r <= mid_r; oto_port_r <= mport_r;
          oent_id_r <= mem_id[ri]; oent_port_r <= mem_port[ri];
          obeat_r <= mem_beat[ri]; oseen_r <= mem_seen[ri];
          olast_r <= (idx_r + 1'b1 == count_r);
          idx_r <= idx_r + 1'b1;
          if (idx_r + 1'b1 == count_r) state_r <= ST_IDLE;
        end
        ST_BEAT: begin
          if (at_end) begin
            own_beat_r <= own_beat_r + 1'b1;
            ping_r <= fail_period_r;
            idx_r <= '0;
            state_r <= ST_EXPIRE;
          end else if (out_free) begin
            ov_r <= 1'b1; okind_r <= KIND_HEARTBEAT;
            oto_id_r <= mem_id[ri]; oto_port_r <= mem_port[ri];
            oent_id_r <= self_id_r; oent_port_r <= self_port_r;
            obeat_r <= own_beat_r; oseen_r <= clock_r;
            olast_r <= (idx_r + 1'b1 == count_r);
            idx_r <= idx_r + 1'b1;
          end
        end
        ST_EXPIRE: begin
          if (at_end) begin
            count_r <= wr_r;
            state_r <= ST_FIN;
          end else begin
            if (!(age > $signed({17'd0, remove_tmo_r}))) begin
              mem_id[wr_r[IW-1:0]]   <= mem_id[ri];
              mem_port[wr_r[IW-1:0]] <= mem_port[ri];
              mem_beat[wr_r[IW-1:0]] <= mem_beat[ri];
              mem_seen[wr_r[IW-1:0]] <= mem_seen[ri];
              wr_r <= wr_r + 1'b1;
            end
            idx_r <= idx_r + 1'b1;
          end
        end
        ST_FIN: begin
          if (typ_r == REQ_TICK) begin
            clock_r <= clock_r + 1'b1;
            if (ping_r != '0 && !found_r) ping_r <= ping_r - 1'b1;
          end
          state_r <= ST_IDLE;
        end
        default: state_r <= ST_IDLE;
      endcase
      // mark the tick that sent heartbeats so the countdown is not applied twice
      if (state_r == ST_BEAT && at_end) found_r <= 1'b1;
    end
  end

  `ASSERT_IMPLIES(a_busy_no_cfg, clk, rst_n, state_r != ST_IDLE, !cfg_ready)
  `ASSERT_IMPLIES(a_count_range, clk, rst_n, 1'b1, count_r <= CW'(TABLE_DEPTH))
  `ASSERT_NEXT(a_hold_out, clk, rst_n, ov_r && out_stall, ov_r && $stable(obeat_r))
endmodule
`default_nettype wire
